>>> rtl/validated_lru_item_cache_top_macros.svh
// Assertion macros shared by the cache RTL.
`ifndef VALIDATED_LRU_ITEM_CACHE_TOP_MACROS_SVH
`define VALIDATED_LRU_ITEM_CACHE_TOP_MACROS_SVH
`define VLC_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
`define VLC_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`endif

>>> rtl/vlc_pkg.sv
// ----------------------------------------------------------------------------
// vlc_pkg
// Shared types and constants of the validated LRU item cache.
// ----------------------------------------------------------------------------
package vlc_pkg;
    localparam int CACHE_ENTRIES = 128;
    localparam int SLOT_W = $clog2(CACHE_ENTRIES);
    localparam int CNT_W = SLOT_W + 1;
    localparam int ID_W = 9;
    localparam int TIME_W = 32;
    localparam int WORD_W = 32;
    localparam int QDEPTH = 2;

    localparam logic [1:0] OUTCOME_CONFIRM = 2'd0;
    localparam logic [1:0] OUTCOME_STALE = 2'd1;
    localparam logic [1:0] OUTCOME_FILL = 2'd2;
    localparam logic [1:0] OUTCOME_EVICT = 2'd3;

    typedef struct packed {
        logic [ID_W-1:0] item_id;
        logic [TIME_W-1:0] now;
        logic [TIME_W-1:0] home_updated_time;
        logic signed [WORD_W-1:0] home_data;
        logic home_kind;
    } query_t;

    typedef struct packed {
        logic [1:0] outcome;
        logic [SLOT_W-1:0] slot;
        logic signed [WORD_W-1:0] item_data;
        logic [TIME_W-1:0] item_updated_time;
        logic item_kind;
    } result_t;
endpackage

>>> rtl/vlc_front.sv
// ----------------------------------------------------------------------------
// vlc_front
// Input beat queue: unpacks tdata and buffers queries for the scan engine.
// ----------------------------------------------------------------------------
module vlc_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [111:0]         s_tdata,
    output logic                 q_valid,
    input  logic                 q_ready,
    output vlc_pkg::query_t      q_data
);
    `include "validated_lru_item_cache_top_macros.svh"

    localparam int PW = $clog2(vlc_pkg::QDEPTH);

    vlc_pkg::query_t    fifo_reg [vlc_pkg::QDEPTH];
    logic [PW-1:0]      wr_reg, rd_reg;
    logic [PW:0]        cnt_reg;
    vlc_pkg::query_t    in_q;
    logic               push, pop;

    assign in_q.item_id           = s_tdata[8:0];
    assign in_q.now               = s_tdata[40:9];
    assign in_q.home_updated_time = s_tdata[72:41];
    assign in_q.home_data         = s_tdata[104:73];
    assign in_q.home_kind         = s_tdata[105];

    assign s_tready = (cnt_reg != (PW+1)'(vlc_pkg::QDEPTH));
    assign q_valid  = (cnt_reg != '0);
    assign q_data   = fifo_reg[rd_reg];
    assign push     = s_tvalid && s_tready;
    assign pop      = q_valid && q_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_reg[wr_reg] <= in_q;
        end
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) wr_reg <= wr_reg + 1'b1;
            if (pop)  rd_reg <= rd_reg + 1'b1;
            cnt_reg <= cnt_reg + (PW+1)'(push) - (PW+1)'(pop);
        end
    end

    `VLC_ASSERT_IMP(a_cnt_bound, aclk, aresetn, 1'b1,
        cnt_reg <= (PW+1)'(vlc_pkg::QDEPTH), "queue count overflow")
    `VLC_ASSERT_NEXT(a_cnt_push, aclk, aresetn, push && !pop,
        cnt_reg == $past(cnt_reg) + 1'b1, "queue count not advanced")
    `VLC_ASSERT_IMP(a_full_stall, aclk, aresetn, !s_tready, q_valid,
        "full queue without data")
endmodule

>>> rtl/vlc_back.sv
// ----------------------------------------------------------------------------
// vlc_back
// Scan engine: walks the slots one a cycle for id match and oldest stamp,
// then updates the chosen slot and holds the result beat.
// ----------------------------------------------------------------------------
module vlc_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 q_valid,
    output logic                 q_ready,
    input  vlc_pkg::query_t      q_data,
    output logic                 r_valid,
    input  logic                 r_ready,
    output vlc_pkg::result_t     r_data
);
    `include "validated_lru_item_cache_top_macros.svh"

    localparam int SW = vlc_pkg::SLOT_W;
    localparam int CW = vlc_pkg::CNT_W;

    typedef enum logic [2:0] {S_IDLE, S_SCAN, S_LAST, S_READ, S_WRITE, S_OUT} state_t;

    typedef struct packed {
        logic [vlc_pkg::ID_W-1:0]   id;
        logic [vlc_pkg::TIME_W-1:0] upd;
        logic [vlc_pkg::WORD_W-1:0] word;
        logic                       kind;
    } rec_t;

    rec_t                       rec_mem [vlc_pkg::CACHE_ENTRIES];
    logic [vlc_pkg::TIME_W-1:0] lru_mem [vlc_pkg::CACHE_ENTRIES];

    state_t                     state_reg;
    vlc_pkg::query_t            q_reg;
    logic [CW-1:0]              fill_reg;
    logic [CW-1:0]              idx_reg;
    logic [SW-1:0]              rd_idx_reg;
    logic                       rd_v_reg;
    rec_t                       rec_rd_reg;
    logic [vlc_pkg::TIME_W-1:0] lru_rd_reg;
    logic                       hit_reg;
    logic [SW-1:0]              hit_slot_reg;
    rec_t                       hit_rec_reg;
    logic [SW-1:0]              best_reg;
    logic [vlc_pkg::TIME_W-1:0] best_t_reg;
    logic                       best_v_reg;
    logic [SW-1:0]              slot_reg;
    rec_t                       cur_reg;
    logic                       r_valid_reg;
    vlc_pkg::result_t           r_data_reg;

    logic                       rd_en;
    logic [SW-1:0]              rd_addr;
    logic                       fill_full;
    logic                       rd_in_fill;
    logic                       match;
    rec_t                       next_rec;

    assign fill_full  = (fill_reg == CW'(vlc_pkg::CACHE_ENTRIES));
    assign rd_in_fill = ({1'b0, rd_idx_reg} < fill_reg);
    assign match      = rd_v_reg && rd_in_fill && (rec_rd_reg.id == q_reg.item_id);
    assign rd_en      = (state_reg == S_SCAN);
    assign rd_addr    = idx_reg[SW-1:0];
    assign q_ready    = (state_reg == S_IDLE);
    assign r_valid    = r_valid_reg;
    assign r_data     = r_data_reg;

    // Record to store: the held one on a fresh hit, else the home copy.
    always_comb begin
        next_rec.id   = q_reg.item_id;
        next_rec.upd  = q_reg.home_updated_time;
        next_rec.word = q_reg.home_data;
        next_rec.kind = q_reg.home_kind;
        if (hit_reg && q_reg.home_updated_time <= hit_rec_reg.upd) next_rec = hit_rec_reg;
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rec_rd_reg <= rec_mem[rd_addr];
            lru_rd_reg <= lru_mem[rd_addr];
        end
        if (state_reg == S_WRITE) begin
            rec_mem[slot_reg] <= cur_reg;
            lru_mem[slot_reg] <= q_reg.now;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            fill_reg    <= '0;
            r_valid_reg <= 1'b0;
            rd_v_reg    <= 1'b0;
        end else begin
            if (r_valid_reg && r_ready) r_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE: begin
                    if (q_valid) begin
                        q_reg      <= q_data;
                        idx_reg    <= '0;
                        hit_reg    <= 1'b0;
                        best_v_reg <= 1'b0;
                        rd_v_reg   <= 1'b0;
                        state_reg  <= S_SCAN;
                    end
                end
                S_SCAN, S_LAST: begin
                    rd_v_reg   <= (state_reg == S_SCAN);
                    rd_idx_reg <= idx_reg[SW-1:0];
                    if (rd_v_reg) begin
                        if (match && !hit_reg) begin
                            hit_reg      <= 1'b1;
                            hit_slot_reg <= rd_idx_reg;
                            hit_rec_reg  <= rec_rd_reg;
                        end
                        if (!best_v_reg || lru_rd_reg < best_t_reg) begin
                            best_v_reg <= 1'b1;
                            best_reg   <= rd_idx_reg;
                            best_t_reg <= lru_rd_reg;
                        end
                    end
                    if (state_reg == S_SCAN) begin
                        idx_reg <= idx_reg + 1'b1;
                        if (idx_reg == CW'(vlc_pkg::CACHE_ENTRIES - 1)) state_reg <= S_LAST;
                    end else begin
                        state_reg <= S_READ;
                    end
                end
                S_READ: begin
                    priority if (hit_reg) begin
                        slot_reg <= hit_slot_reg;
                    end else if (!fill_full) begin
                        slot_reg <= fill_reg[SW-1:0];
                    end else begin
                        slot_reg <= best_reg;
                    end
                    cur_reg   <= next_rec;
                    state_reg <= S_WRITE;
                end
                S_WRITE: begin
                    state_reg <= S_OUT;
                end
                S_OUT: begin
                    if (!r_valid_reg || r_ready) begin
                        r_valid_reg          <= 1'b1;
                        r_data_reg.slot      <= slot_reg;
                        r_data_reg.item_data <= cur_reg.word;
                        r_data_reg.item_updated_time <= cur_reg.upd;
                        r_data_reg.item_kind <= cur_reg.kind;
                        priority if (hit_reg && q_reg.home_updated_time <= hit_rec_reg.upd)
                            r_data_reg.outcome <= vlc_pkg::OUTCOME_CONFIRM;
                        else if (hit_reg)
                            r_data_reg.outcome <= vlc_pkg::OUTCOME_STALE;
                        else if (!fill_full)
                            r_data_reg.outcome <= vlc_pkg::OUTCOME_FILL;
                        else
                            r_data_reg.outcome <= vlc_pkg::OUTCOME_EVICT;
                        if (!hit_reg && !fill_full) fill_reg <= fill_reg + 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    `VLC_ASSERT_IMP(a_fill_bound, aclk, aresetn, 1'b1,
        fill_reg <= CW'(vlc_pkg::CACHE_ENTRIES), "fill count overflow")
    `VLC_ASSERT_IMP(a_busy_ready, aclk, aresetn, state_reg != S_IDLE, !q_ready,
        "query taken while busy")
    `VLC_ASSERT_NEXT(a_out_beat, aclk, aresetn,
        state_reg == S_OUT && (!r_valid_reg || r_ready), r_valid_reg && state_reg == S_IDLE,
        "result beat not issued")
endmodule

>>> rtl/validated_lru_item_cache_top.sv
// ----------------------------------------------------------------------------
// validated_lru_item_cache_top
// Fully associative 128-slot item cache with LRU replacement and home-copy
// freshness check. Each query runs one memory read per slot to compare ids
// and track the oldest stamp, then the last compare, slot and record select,
// write and result. A two-beat input queue takes new queries while one is
// scanned; the result register holds one beat.
// ----------------------------------------------------------------------------
module validated_lru_item_cache_top (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // item_id[8:0], now[40:9], home_updated_time[72:41], home_data[104:73],
    // home_kind[105], zero fill
    input  logic [111:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // outcome[1:0], slot[8:2], item_data[40:9], item_updated_time[72:41],
    // item_kind[73], zero fill
    output logic [79:0]  m_tdata
);
    logic             q_valid, q_ready;
    vlc_pkg::query_t  q_data;
    vlc_pkg::result_t r_data;

    vlc_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data)
    );

    vlc_back u_back (
        .aclk(aclk), .aresetn(aresetn),
        .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data),
        .r_valid(m_tvalid), .r_ready(m_tready), .r_data(r_data)
    );

    assign m_tdata = {6'd0, r_data.item_kind, r_data.item_updated_time,
                      r_data.item_data, r_data.slot, r_data.outcome};
endmodule

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the validated LRU item cache. A behavioral cache
// copy predicts outcome, slot and held record for every accepted query beat;
// result beats are compared in order. Stimulus covers directed corners, a
// hot working set with fills, confirms, stale refreshes and evictions, plus
// long output stalls and a drain pause.
// ----------------------------------------------------------------------------
class cache_scoreboard;
    logic [vlc_pkg::ID_W-1:0]   ids   [vlc_pkg::CACHE_ENTRIES];
    logic [vlc_pkg::TIME_W-1:0] upd   [vlc_pkg::CACHE_ENTRIES];
    logic [vlc_pkg::WORD_W-1:0] words [vlc_pkg::CACHE_ENTRIES];
    logic                       kinds [vlc_pkg::CACHE_ENTRIES];
    logic [vlc_pkg::TIME_W-1:0] stamps[vlc_pkg::CACHE_ENTRIES];
    int                         used;
    vlc_pkg::result_t           pending[$];
    int                         errors;
    int                         checked;
    int                         outcome_seen[4];

    function void note_query(logic [111:0] beat);
        int s;
        bit hit;
        vlc_pkg::result_t r;
        vlc_pkg::query_t q;
        q.item_id = beat[8:0];
        q.now = beat[40:9];
        q.home_updated_time = beat[72:41];
        q.home_data = beat[104:73];
        q.home_kind = beat[105];
        hit = 0;
        s = 0;
        for (int i = 0; i < used; i++) begin
            if (!hit && ids[i] == q.item_id) begin
                hit = 1;
                s = i;
            end
        end
        if (hit) begin
            if (q.home_updated_time > upd[s]) begin
                r.outcome = vlc_pkg::OUTCOME_STALE;
            end else begin
                r.outcome = vlc_pkg::OUTCOME_CONFIRM;
            end
        end else if (used < vlc_pkg::CACHE_ENTRIES) begin
            s = used;
            used++;
            r.outcome = vlc_pkg::OUTCOME_FILL;
        end else begin
            s = 0;
            for (int i = 1; i < vlc_pkg::CACHE_ENTRIES; i++)
                if (stamps[i] < stamps[s]) s = i;
            r.outcome = vlc_pkg::OUTCOME_EVICT;
        end
        if (r.outcome != vlc_pkg::OUTCOME_CONFIRM) begin
            ids[s] = q.item_id;
            upd[s] = q.home_updated_time;
            words[s] = q.home_data;
            kinds[s] = q.home_kind;
        end
        stamps[s] = q.now;
        r.slot = s[vlc_pkg::SLOT_W-1:0];
        r.item_data = words[s];
        r.item_updated_time = upd[s];
        r.item_kind = kinds[s];
        outcome_seen[r.outcome]++;
        pending.push_back(r);
    endfunction

    function void check_result(logic [79:0] beat);
        vlc_pkg::result_t want;
        logic [1:0] oc;
        logic [vlc_pkg::SLOT_W-1:0] sl;
        logic [vlc_pkg::WORD_W-1:0] dw;
        logic [vlc_pkg::TIME_W-1:0] ut;
        logic kd;
        oc = beat[1:0];
        sl = beat[8:2];
        dw = beat[40:9];
        ut = beat[72:41];
        kd = beat[73];
        checked++;
        if (pending.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result beat %h", beat);
            return;
        end
        want = pending.pop_front();
        if (oc !== want.outcome || sl !== want.slot || dw !== want.item_data ||
            ut !== want.item_updated_time || kd !== want.item_kind) begin
            errors++;
            if (errors <= 10) begin
                $display("mismatch: exp oc=%0d slot=%0d data=%h upd=%h kind=%b",
                         want.outcome, want.slot, want.item_data,
                         want.item_updated_time, want.item_kind);
                $display("          got oc=%0d slot=%0d data=%h upd=%h kind=%b",
                         oc, sl, dw, ut, kd);
            end
        end
    endfunction
endclass

module tb;
    logic         aclk = 0;
    logic         aresetn = 0;
    logic         s_tvalid = 0;
    logic         s_tready;
    logic [111:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 0;
    logic [79:0]  m_tdata;

    cache_scoreboard sb = new();
    logic [vlc_pkg::TIME_W-1:0] tick = 0;
    int  sent = 0;
    bit  hold_off = 0;
    bit  quiet_out = 0;
    bit  stim_done = 0;
    longint cycles = 0;

    validated_lru_item_cache_top u_top (.*);

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > 4000000) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    always @(posedge aclk)
        if (aresetn) begin
            if (s_tvalid && s_tready) sb.note_query(s_tdata);
            if (m_tvalid && m_tready) sb.check_result(m_tdata);
        end

    // receiver: random stalls per beat, optional long hold-off
    initial begin
        int gap;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_off) begin
                m_tready <= 0;
            end else if (!m_tready) begin
                gap = quiet_out ? 0 : $urandom_range(0, 17);
                repeat (gap) @(negedge aclk);
                if (!hold_off) m_tready <= 1;
            end else if (m_tvalid) begin
                if (!quiet_out && $urandom_range(0, 3) == 0) m_tready <= 0;
            end
        end
    end

    // valid stays high after a beat; callers drop it before waiting
    task automatic send_query(logic [vlc_pkg::ID_W-1:0] id,
                              logic [vlc_pkg::TIME_W-1:0] now_t,
                              logic [vlc_pkg::TIME_W-1:0] ht,
                              logic [vlc_pkg::WORD_W-1:0] hw,
                              logic hk, bit no_gap);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            s_tvalid <= 0;
            repeat (gap) @(negedge aclk);
        end
        s_tdata <= {6'b0, hk, hw, ht, now_t, id};
        s_tvalid <= 1;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        sent++;
    endtask

    task automatic rand_query(int id_span, bit no_gap);
        logic [vlc_pkg::ID_W-1:0] id;
        logic [vlc_pkg::TIME_W-1:0] ht;
        logic [31:0] pick;
        logic [31:0] kind_pick;
        pick = (id_span >= 512) ? $urandom_range(0, 511) : $urandom_range(0, id_span - 1);
        id = pick[vlc_pkg::ID_W-1:0];
        tick = tick + $urandom_range(0, 3);
        case ($urandom_range(0, 3))
            0: ht = 32'hFFFF_FFFF - $urandom_range(0, 2);
            1: ht = $urandom_range(0, 3);
            default: ht = $urandom_range(0, 40);
        endcase
        kind_pick = $urandom_range(0, 1);
        send_query(id, ($urandom_range(0, 30) == 0) ? $urandom : tick, ht, $urandom,
                   kind_pick[0], no_gap);
    endtask

    task automatic wait_drain();
        do @(posedge aclk); while (sb.pending.size() != 0);
        @(negedge aclk);
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1;
        // directed: id 0 on empty cache, extremes, confirm, stale, equal ticks
        send_query(0, 5, 0, 32'h8000_0000, 0, 0);
        send_query(0, 6, 0, 32'h7FFF_FFFF, 1, 0);
        send_query(0, 7, 1, 32'h7FFF_FFFF, 1, 0);
        send_query(511, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 0);
        send_query(511, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 0, 0, 0);
        send_query(256, 32'hFFFF_FFFF, 32'hAAAA_5555, 32'h5555_AAAA, 0, 0);
        send_query(256, 3, 32'hAAAA_5556, 32'hAAAA_5555, 1, 0);
        send_query(1, 3, 0, 0, 0, 0);
        send_query(2, 3, 0, 1, 1, 0);
        send_query(1, 3, 0, 2, 0, 0);
        // fill every slot, then evict: ties on stamp 3 resolve to lowest slot
        tick = 10;
        for (int i = 10; i < 10 + vlc_pkg::CACHE_ENTRIES; i++) begin
            tick++;
            send_query(i[vlc_pkg::ID_W-1:0], tick, i, i, i[0], 1);
        end
        send_query(400, 1, 9, 9, 1, 0);
        send_query(401, 1, 9, 9, 0, 0);
        send_query(402, 2, 9, 9, 1, 0);
        // long receiver hold-off while sender keeps offering beats
        hold_off = 1;
        fork
            begin
                for (int i = 0; i < 12; i++) rand_query(200, 1);
                s_tvalid <= 0;
            end
            begin
                repeat (3000) @(posedge aclk);
                hold_off = 0;
            end
        join
        wait_drain();
        // random body: mostly a working set near cache size, some full range
        for (int n = 0; n < 1250; n++) begin
            if (n == 700) begin
                s_tvalid <= 0;
                wait_drain();
            end
            quiet_out = (n >= 900 && n < 1000);
            rand_query(($urandom_range(0, 4) == 0) ? 512 : 160, n >= 900 && n < 1000);
        end
        s_tvalid <= 0;
        quiet_out = 0;
        stim_done = 1;
        while (sb.pending.size() != 0 && cycles < 3900000) @(posedge aclk);
        repeat (300) @(posedge aclk);
        $display("covered %0d queries: confirm %0d, stale %0d, fill %0d, evict %0d",
                 sent, sb.outcome_seen[vlc_pkg::OUTCOME_CONFIRM],
                 sb.outcome_seen[vlc_pkg::OUTCOME_STALE],
                 sb.outcome_seen[vlc_pkg::OUTCOME_FILL],
                 sb.outcome_seen[vlc_pkg::OUTCOME_EVICT]);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
